FILE: rtl/calculator_key_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Calculator key engine assertion macros
// Shared concurrent assertion shorthands for the key engine RTL.
// ----------------------------------------------------------------------------
`ifndef CALCULATOR_KEY_ENGINE_TOP_MACROS_SVH
`define CALCULATOR_KEY_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CKE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key engine same-cycle check failed");

// Next-cycle implication, checked out of reset
`define CKE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key engine next-cycle check failed");

`endif

FILE: rtl/cke_pkg.sv
// ----------------------------------------------------------------------------
// Calculator key engine package
// Key codes, operator codes, state encodings and shared structs.
// ----------------------------------------------------------------------------
package cke_pkg;

  // Key codes
  typedef enum logic [3:0] {
    CMD_DIGIT   = 4'd0,
    CMD_NEGATE  = 4'd1,
    CMD_ROOT    = 4'd2,
    CMD_POINT   = 4'd3,
    CMD_ADD     = 4'd4,
    CMD_SUB     = 4'd5,
    CMD_MUL     = 4'd6,
    CMD_DIV     = 4'd7,
    CMD_EQUALS  = 4'd8,
    CMD_CLEAR   = 4'd9,
    CMD_PERCENT = 4'd10
  } cmd_t;

  // Pending operator codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // Offset from an operator key code to its operator code
  localparam logic [3:0] CMD_OP_BASE = 4'd3;

  // Divisor for percent
  localparam logic [63:0] PERCENT_DIV = 64'd100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIGIT,
    S_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    K_MUL,
    K_DIV,
    K_ROOT
  } kind_t;

  // Control into the serial unit
  typedef struct packed {
    logic  start;
    kind_t kind;
  } unit_ctl_t;

  // Status out of the serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Saturated value with overflow mark
  typedef struct packed {
    logic [63:0] val;
    logic        ov;
  } sat_res_t;

endpackage

FILE: rtl/cke_serial_unit.sv
// ----------------------------------------------------------------------------
// Calculator key engine serial arithmetic unit
// Bit-serial multiply, restoring divide and digit-by-digit square root.
// ----------------------------------------------------------------------------
module cke_serial_unit
  import cke_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  unit_ctl_t    ctl,
  input  logic [127:0] opa,   // multiplier, dividend or radicand
  input  logic [63:0]  opb,   // multiplicand or divisor
  output unit_stat_t   stat,
  output logic [127:0] res    // product, quotient or root
);

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  kind_t        kind_r, kind_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [127:0] sh_r, sh_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [65:0]  rem_r, rem_nxt;
  logic [63:0]  opb_r, opb_nxt;

  logic [64:0]  mul_sum;
  logic [64:0]  div_rem;
  logic [65:0]  root_rem;
  logic [65:0]  root_trial;

  // Load a new operation on start, else run one step of the selected operation
  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    kind_nxt   = kind_r;
    cnt_nxt    = cnt_r;
    sh_nxt     = sh_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    opb_nxt    = opb_r;
    mul_sum    = {1'b0, acc_r[127:64]} + (sh_r[0] ? {1'b0, opb_r} : 65'd0);
    div_rem    = {rem_r[63:0], sh_r[127]};
    root_rem   = {rem_r[63:0], sh_r[127:126]};
    root_trial = {acc_r[63:0], 2'b01};
    if (ctl.start) begin
      busy_nxt = 1'b1;
      kind_nxt = ctl.kind;
      cnt_nxt  = (ctl.kind == K_DIV) ? 7'd127 : 7'd63;
      sh_nxt   = opa;
      acc_nxt  = '0;
      rem_nxt  = '0;
      opb_nxt  = opb;
    end else if (busy_r) begin
      unique case (kind_r)
        K_MUL: begin
          acc_nxt = {mul_sum, acc_r[63:1]};
          sh_nxt  = {1'b0, sh_r[127:1]};
        end
        K_DIV: begin
          sh_nxt = {sh_r[126:0], 1'b0};
          if (div_rem >= {1'b0, opb_r}) begin
            rem_nxt = {1'b0, div_rem - {1'b0, opb_r}};
            acc_nxt = {acc_r[126:0], 1'b1};
          end else begin
            rem_nxt = {1'b0, div_rem};
            acc_nxt = {acc_r[126:0], 1'b0};
          end
        end
        K_ROOT: begin
          sh_nxt = {sh_r[125:0], 2'b00};
          if (root_rem >= root_trial) begin
            rem_nxt = root_rem - root_trial;
            acc_nxt = {acc_r[126:0], 1'b1};
          end else begin
            rem_nxt = root_rem;
            acc_nxt = {acc_r[126:0], 1'b0};
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    cnt_r  <= cnt_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    opb_r  <= opb_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = acc_r;

endmodule

FILE: rtl/calculator_key_engine_top.sv
// Key transfer to result transfer: most keys go through S_OUT, digits through S_DIGIT
// then S_OUT; a key completing a multiply or taking a square root (64 serial unit
// steps) or completing a divide or taking a percent (128) goes through S_WAIT, S_OUT.
// One key at a time: the next key is taken in the cycle after the result register
// loads, even while that result still waits on the output.
// Reset (rst_n low, synchronous): zero value, no operator, fresh entry.
// ----------------------------------------------------------------------------
// Calculator key engine top level
// Immediate-execution four-function calculator over signed fixed point.
// ----------------------------------------------------------------------------
`include "calculator_key_engine_top_macros.svh"

module calculator_key_engine_top
  import cke_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int FRAC_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] digit, [7:4] zero
  input  logic [3:0]  in_tuser,   // [3:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] shown_value, [66:64] pending_operator,
                                  // [67] error_flag, [68] overflow_flag, [71:69] zero
);

  localparam logic [63:0] POS_LIM = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  state_t      state_r, state_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] entry_r, entry_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        fresh_r, fresh_nxt;
  logic        err_r, err_nxt;
  logic        ov_r, ov_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        sgn_r, sgn_nxt;
  logic [3:0]  dig_r, dig_nxt;
  logic [67:0] tmp_r, tmp_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r, out_data_nxt;

  unit_ctl_t    ctl;
  unit_stat_t   ustat;
  logic [127:0] opa;
  logic [63:0]  opb;
  logic [127:0] ures;

  cmd_t        cmd_in;
  logic [63:0] acc_mag, entry_mag;
  logic [67:0] base68, sum68;
  sat_res_t    sr;
  logic [2:0]  op_of_cmd;

  // Clamp a signed wide value to the value range
  function automatic sat_res_t sat_signed(input logic signed [67:0] x);
    sat_res_t r;
    logic signed [67:0] hi, lo;
    hi   = $signed({4'd0, POS_LIM});
    lo   = -hi - 68'sd1;
    r.ov = 1'b0;
    r.val = x[63:0];
    if (x > hi) begin
      r.val = POS_LIM;
      r.ov  = 1'b1;
    end else if (x < lo) begin
      r.val = lo[63:0];
      r.ov  = 1'b1;
    end
    return r;
  endfunction

  // Clamp a sign and magnitude to the value range
  function automatic sat_res_t sat_mag(input logic neg, input logic [127:0] mag);
    sat_res_t r;
    logic [63:0] lim, m;
    lim  = POS_LIM + {63'd0, neg};
    m    = mag[63:0];
    r.ov = 1'b0;
    if ((mag[127:64] != 64'd0) || (m > lim)) begin
      m    = lim;
      r.ov = 1'b1;
    end
    r.val = neg ? (64'd0 - m) : m;
    return r;
  endfunction

  assign cmd_in    = cmd_t'(in_tuser);
  assign acc_mag   = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign entry_mag = entry_r[63] ? (64'd0 - entry_r) : entry_r;
  assign in_tready = (state_r == S_IDLE);

  // Sequence one key through its steps
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    entry_nxt = entry_r;
    pend_nxt  = pend_r;
    fresh_nxt = fresh_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r;
    cmd_nxt   = cmd_r;
    sgn_nxt   = sgn_r;
    dig_nxt   = dig_r;
    tmp_nxt   = tmp_r;
    ctl.start = 1'b0;
    ctl.kind  = K_MUL;
    opa       = {64'd0, acc_mag};
    opb       = entry_mag;
    base68    = fresh_r ? 68'd0 : {{4{entry_r[63]}}, entry_r};
    sum68     = 68'd0;
    sr        = '0;
    op_of_cmd = (cmd_r == CMD_EQUALS) ? OP_NONE : 3'(cmd_r - CMD_OP_BASE);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_in;
          err_nxt   = 1'b0;
          ov_nxt    = 1'b0;
          state_nxt = S_OUT;
          case (cmd_in) inside
            CMD_DIGIT: begin
              tmp_nxt   = (base68 << 3) + (base68 << 1);
              dig_nxt   = in_tdata[3:0];
              fresh_nxt = 1'b0;
              state_nxt = S_DIGIT;
            end
            CMD_NEGATE: begin
              sr        = sat_signed(68'sd0 - $signed({{4{entry_r[63]}}, entry_r}));
              entry_nxt = sr.val;
              ov_nxt    = sr.ov;
              fresh_nxt = 1'b0;
            end
            CMD_ROOT: begin
              if (entry_r[63]) begin
                err_nxt = 1'b1;
              end else if (!fresh_r) begin
                ctl.start = 1'b1;
                ctl.kind  = K_ROOT;
                opa       = {64'd0, entry_r} << FRAC_BITS;
                state_nxt = S_WAIT;
              end
            end
            CMD_POINT: begin
              fresh_nxt = 1'b0;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQUALS: begin
              if (pend_r != OP_NONE && !fresh_r) begin
                if (pend_r == OP_ADD || pend_r == OP_SUB) begin
                  sum68 = (pend_r == OP_ADD)
                        ? {{4{acc_r[63]}}, acc_r} + {{4{entry_r[63]}}, entry_r}
                        : {{4{acc_r[63]}}, acc_r} - {{4{entry_r[63]}}, entry_r};
                  sr        = sat_signed(sum68);
                  acc_nxt   = sr.val;
                  entry_nxt = sr.val;
                  ov_nxt    = sr.ov;
                  fresh_nxt = 1'b1;
                  pend_nxt  = (cmd_in == CMD_EQUALS) ? OP_NONE : 3'(in_tuser - CMD_OP_BASE);
                end else if (pend_r == OP_DIV && entry_r == 64'd0) begin
                  err_nxt   = 1'b1;
                  acc_nxt   = 64'd0;
                  entry_nxt = 64'd0;
                  pend_nxt  = OP_NONE;
                  fresh_nxt = 1'b1;
                end else begin
                  sgn_nxt   = acc_r[63] ^ entry_r[63];
                  ctl.start = 1'b1;
                  ctl.kind  = (pend_r == OP_MUL) ? K_MUL : K_DIV;
                  opa       = (pend_r == OP_MUL) ? {64'd0, acc_mag}
                                                 : ({64'd0, acc_mag} << FRAC_BITS);
                  opb       = entry_mag;
                  state_nxt = S_WAIT;
                end
              end else if (cmd_in != CMD_EQUALS) begin
                if (pend_r == OP_NONE) begin
                  acc_nxt = entry_r;
                end
                pend_nxt  = 3'(in_tuser - CMD_OP_BASE);
                fresh_nxt = 1'b1;
              end
            end
            CMD_CLEAR: begin
              acc_nxt   = 64'd0;
              entry_nxt = 64'd0;
              pend_nxt  = OP_NONE;
              fresh_nxt = 1'b1;
            end
            CMD_PERCENT: begin
              sgn_nxt   = entry_r[63];
              ctl.start = 1'b1;
              ctl.kind  = K_DIV;
              opa       = {64'd0, entry_mag};
              opb       = PERCENT_DIV;
              fresh_nxt = 1'b1;
              state_nxt = S_WAIT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_DIGIT: begin
        sr        = sat_signed(tmp_r + (68'(dig_r) << FRAC_BITS));
        entry_nxt = sr.val;
        ov_nxt    = sr.ov;
        state_nxt = S_OUT;
      end
      S_WAIT: begin
        if (ustat.done) begin
          state_nxt = S_OUT;
          case (cmd_r)
            CMD_ROOT: begin
              sr        = sat_mag(1'b0, ures);
              entry_nxt = sr.val;
              ov_nxt    = sr.ov;
              fresh_nxt = 1'b1;
            end
            CMD_PERCENT: begin
              sr        = sat_mag(sgn_r, ures);
              entry_nxt = sr.val;
            end
            default: begin
              sr        = (pend_r == OP_MUL) ? sat_mag(sgn_r, ures >> FRAC_BITS)
                                             : sat_mag(sgn_r, ures);
              acc_nxt   = sr.val;
              entry_nxt = sr.val;
              ov_nxt    = sr.ov;
              fresh_nxt = 1'b1;
              pend_nxt  = op_of_cmd;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, ov_r, err_r, pend_r, entry_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold calculator and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= 64'd0;
      entry_r     <= 64'd0;
      pend_r      <= OP_NONE;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      entry_r     <= entry_nxt;
      pend_r      <= pend_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold per-key payload
  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    ov_r       <= ov_nxt;
    cmd_r      <= cmd_nxt;
    sgn_r      <= sgn_nxt;
    dig_r      <= dig_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
  end

  cke_serial_unit u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .opa   (opa),
    .opb   (opb),
    .stat  (ustat),
    .res   (ures)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `CKE_ASSERT_IMPL(a_ready_not_busy, in_tready, !ustat.busy)
  `CKE_ASSERT_IMPL(a_done_in_wait, ustat.done, state_r == S_WAIT)
  `CKE_ASSERT_NEXT(a_start_busy, ctl.start, ustat.busy)

endmodule

FILE: test/tb_calculator_key_engine_top.sv
// ----------------------------------------------------------------------------
// Calculator key engine testbench
// Drives key transfers with random gaps, predicts every result with an
// independent fixed point calculator and checks each output field.
// ----------------------------------------------------------------------------
module tb_calculator_key_engine_top;
  import cke_pkg::*;

  localparam int FRAC      = 24;
  localparam int N_RANDOM  = 1850;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] dig;
  } key_t;

  typedef struct packed {
    logic [63:0] shown;
    logic [2:0]  pend;
    logic        err;
    logic        ovf;
  } display_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  key_t     key_queue[$];
  display_t expected_displays[$];
  key_t     key_on_bus;
  int       send_gap;
  int       recv_stall;
  int       idle_cycles;
  bit       quiet_send;
  bit       quiet_recv;
  bit       failed;

  // Calculator state mirror
  logic signed [63:0] acc_q;
  logic signed [63:0] entry_q;
  logic [2:0]         pend_q;
  logic               fresh_q;
  logic               calc_ov;

  calculator_key_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [127:0] magnitude(logic signed [63:0] x);
    return {64'd0, x[63] ? (~x + 64'd1) : x};
  endfunction

  // Clamp a sign-magnitude value into the signed 64-bit range
  function automatic logic signed [63:0] saturate(logic neg, logic [127:0] m);
    logic [127:0] lim;
    lim = {64'd0, 64'h7FFF_FFFF_FFFF_FFFF} + (neg ? 128'd1 : 128'd0);
    if (m > lim) begin
      calc_ov = 1'b1;
      m = lim;
    end
    return neg ? -m[63:0] : m[63:0];
  endfunction

  function automatic void add_signed(input logic na, input logic [127:0] ma,
                                     input logic nb, input logic [127:0] mb,
                                     output logic nr, output logic [127:0] mr);
    if (na == nb) begin
      mr = ma + mb;
      nr = na;
    end else if (ma >= mb) begin
      mr = ma - mb;
      nr = na;
    end else begin
      mr = mb - ma;
      nr = nb;
    end
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] num;
    logic [127:0] res;
    logic [127:0] b;
    num = v;
    res = '0;
    b = 128'd1 << 126;
    while (b > num) b = b >> 2;
    while (b != 0) begin
      if (num >= res + b) begin
        num = num - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Run the pending operator on accumulator and entry; 0 on divide by zero
  function automatic bit finish_operation();
    logic         nr;
    logic [127:0] mr;
    logic [127:0] ma;
    logic [127:0] mb;
    ma = magnitude(acc_q);
    mb = magnitude(entry_q);
    case (pend_q)
      OP_ADD: add_signed(acc_q[63], ma, entry_q[63], mb, nr, mr);
      OP_SUB: add_signed(acc_q[63], ma, ~entry_q[63], mb, nr, mr);
      OP_MUL: begin
        mr = (ma * mb) >> FRAC;
        nr = acc_q[63] ^ entry_q[63];
      end
      OP_DIV: begin
        if (mb == 0) return 1'b0;
        mr = (ma << FRAC) / mb;
        nr = acc_q[63] ^ entry_q[63];
      end
      default: return 1'b1;
    endcase
    acc_q = saturate(nr, mr);
    return 1'b1;
  endfunction

  task automatic clear_all();
    acc_q = '0;
    entry_q = '0;
    pend_q = OP_NONE;
    fresh_q = 1'b1;
  endtask

  // Advance the calculator mirror by one key and queue the display it shows
  task automatic predict_key(input key_t k);
    logic         nr;
    logic [127:0] mr;
    logic         err;
    bit           ok;
    display_t     d;
    err = 1'b0;
    calc_ov = 1'b0;
    case (k.cmd) inside
      CMD_DIGIT: begin
        if (fresh_q) begin
          entry_q = '0;
          fresh_q = 1'b0;
        end
        add_signed(entry_q[63], magnitude(entry_q) * 128'd10, 1'b0,
                   {124'd0, k.dig} << FRAC, nr, mr);
        entry_q = saturate(nr, mr);
      end
      CMD_NEGATE: begin
        entry_q = saturate(~entry_q[63], magnitude(entry_q));
        fresh_q = 1'b0;
      end
      CMD_ROOT: begin
        if (entry_q < 0) begin
          err = 1'b1;
        end else if (!fresh_q) begin
          entry_q = saturate(1'b0, isqrt({64'd0, entry_q} << FRAC));
          fresh_q = 1'b1;
        end
      end
      CMD_POINT: fresh_q = 1'b0;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQUALS: begin
        ok = 1'b1;
        if (pend_q != OP_NONE && !fresh_q) begin
          ok = finish_operation();
          if (ok) entry_q = acc_q;
        end else if (k.cmd != CMD_EQUALS && pend_q == OP_NONE) begin
          acc_q = entry_q;
        end
        if (!ok) begin
          err = 1'b1;
          clear_all();
        end else if (k.cmd == CMD_EQUALS) begin
          if (pend_q != OP_NONE && !fresh_q) begin
            pend_q = OP_NONE;
            fresh_q = 1'b1;
          end
        end else begin
          pend_q = 3'(k.cmd - CMD_OP_BASE);
          fresh_q = 1'b1;
        end
      end
      CMD_CLEAR: clear_all();
      CMD_PERCENT: begin
        entry_q = entry_q / $signed(PERCENT_DIV);
        fresh_q = 1'b1;
      end
      default: ;
    endcase
    d.shown = entry_q;
    d.pend = pend_q;
    d.err = err;
    d.ovf = calc_ov;
    expected_displays.push_back(d);
  endtask

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic push_key(input cmd_t c, input logic [3:0] v);
    key_t k;
    k.cmd = c;
    k.dig = v;
    key_queue.push_back(k);
  endtask

  // Driver: present queued keys, predict on each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      send_gap <= 0;
      quiet_send <= 1'b0;
      clear_all();
      calc_ov = 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_key(key_on_bus);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (key_queue.size() > 0) begin
          key_on_bus = key_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= key_on_bus.cmd;
          in_tdata <= {4'd0, key_on_bus.dig};
          if ($urandom_range(0, 99) == 0) quiet_send <= ~quiet_send;
          send_gap <= draw_wait(quiet_send);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
      quiet_recv <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_displays.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          failed = 1'b1;
        end else begin
          display_t e;
          e = expected_displays.pop_front();
          if (out_tdata[63:0] !== e.shown) begin
            $display("%0t: shown_value expected %h actual %h", $time, e.shown,
                     out_tdata[63:0]);
            failed = 1'b1;
          end
          if (out_tdata[66:64] !== e.pend) begin
            $display("%0t: pending_operator expected %0d actual %0d", $time, e.pend,
                     out_tdata[66:64]);
            failed = 1'b1;
          end
          if (out_tdata[67] !== e.err) begin
            $display("%0t: error_flag expected %b actual %b", $time, e.err, out_tdata[67]);
            failed = 1'b1;
          end
          if (out_tdata[68] !== e.ovf) begin
            $display("%0t: overflow_flag expected %b actual %b", $time, e.ovf,
                     out_tdata[68]);
            failed = 1'b1;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 99) == 0) quiet_recv <= ~quiet_recv;
        recv_stall <= draw_wait(quiet_recv);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    rst_n = 1'b0;

    // Directed: digits incl. out-of-range values, roots, saturate, negate, percent, divide by zero
    push_key(CMD_DIGIT, 4'd9);
    push_key(CMD_DIGIT, 4'd15);
    push_key(CMD_ROOT, 4'd0);
    push_key(CMD_ROOT, 4'd0);
    push_key(CMD_NEGATE, 4'd0);
    push_key(CMD_ROOT, 4'd0);
    for (int i = 0; i < 14; i++) push_key(CMD_DIGIT, 4'd9);
    push_key(CMD_NEGATE, 4'd0);
    push_key(CMD_PERCENT, 4'd0);
    push_key(CMD_NEGATE, 4'd0);
    push_key(CMD_MUL, 4'd0);
    push_key(CMD_EQUALS, 4'd0);
    push_key(CMD_DIGIT, 4'd7);
    push_key(CMD_DIV, 4'd0);
    push_key(CMD_DIGIT, 4'd0);
    push_key(CMD_EQUALS, 4'd0);
    push_key(CMD_POINT, 4'd0);
    push_key(CMD_SUB, 4'd0);
    push_key(CMD_ADD, 4'd0);
    push_key(cmd_t'(4'd15), 4'd0);
    push_key(CMD_CLEAR, 4'd0);

    // Random: mostly number-operator-number sequences with random keys mixed in
    n = 0;
    while (n < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_key(CMD_DIGIT, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0) push_key(CMD_NEGATE, 4'($urandom));
        push_key(cmd_t'(4'($urandom_range(CMD_ADD, CMD_EQUALS))), 4'($urandom));
        n += len + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) push_key(CMD_ROOT, 4'($urandom));
        else if (r < 45) push_key(CMD_PERCENT, 4'($urandom));
        else if (r < 60) push_key(CMD_NEGATE, 4'($urandom));
        else if (r < 70) push_key(CMD_POINT, 4'($urandom));
        else if (r < 80) push_key(CMD_CLEAR, 4'($urandom));
        else if (r < 88) push_key(cmd_t'(4'($urandom_range(11, 15))), 4'($urandom));
        else push_key(cmd_t'(4'($urandom_range(CMD_ADD, CMD_EQUALS))), 4'($urandom));
        n++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all keys sent, all displays seen, then settle
    wait (key_queue.size() == 0 && !in_tvalid && expected_displays.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_displays.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
